@@ hw/rtl/tshc_pkg.sv @@
// Shared types and constants for the turn-signal and hazard flasher.
// No dependencies; imported by tshc_mode_fsm and turn_signal_hazard_controller.
package tshc_pkg;

    // Widths fixed by the register map and the result fields.
    localparam int unsigned THR_W   = 8;
    localparam int unsigned BLINK_W = 8;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // Largest compare value the PWM timer accepts.
    localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd999;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DUTY    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]   RST_LONG_PRESS = 8'd10;
    localparam logic [BLINK_W-1:0] RST_BLINK_HALF = 8'd3;
    localparam logic [DUTY_W-1:0]  RST_ON_DUTY    = 10'd500;

    // Mode codes as reported on the result channel.
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HAZARD = 2'd3;

    // Mode machine states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LEFT   = 4'b0010,
        ST_RIGHT  = 4'b0100,
        ST_HAZARD = 4'b1000
    } t_mode_state;

    // What the mode machine tells the lamp logic after this tick.
    typedef struct packed {
        logic              left_on;
        logic              right_on;
        logic [MODE_W-1:0] mode;
    } t_mode_status;

endpackage

@@ hw/rtl/tshc_mode_fsm.sv @@
// Held-time counters, long-press detection and the four-mode machine.
// Depends on tshc_pkg.
module tshc_mode_fsm #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic                      i_left_pressed,
    input  logic                      i_right_pressed,
    input  logic [tshc_pkg::THR_W-1:0] i_long_press_ticks,
    output tshc_pkg::t_mode_status    o_next_status
);
    import tshc_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    logic [COUNT_WIDTH-1:0] r_left_held, n_left_held;
    logic [COUNT_WIDTH-1:0] r_right_held, n_right_held;
    logic [COUNT_WIDTH-1:0] w_left_inc, w_right_inc;
    logic [THR_W-1:0]       w_thr;
    logic                   w_left_ev, w_right_ev;
    t_mode_state            r_state, n_state;

    // Held counters saturate at all ones and clear when the button is released.
    always_comb begin
        w_left_inc  = (&r_left_held)  ? r_left_held  : r_left_held  + 1'b1;
        w_right_inc = (&r_right_held) ? r_right_held : r_right_held + 1'b1;
        w_left_inc  = i_left_pressed  ? w_left_inc  : '0;
        w_right_inc = i_right_pressed ? w_right_inc : '0;
    end

    // A zero threshold behaves as one tick.
    assign w_thr = (i_long_press_ticks == '0) ? {{(THR_W-1){1'b0}}, 1'b1}
                                              : i_long_press_ticks;

    assign w_left_ev  = CMP_W'(w_left_inc)  >= CMP_W'(w_thr);
    assign w_right_ev = CMP_W'(w_right_inc) >= CMP_W'(w_thr);

    // Mode transitions; any event clears both held counters.
    always_comb begin
        n_state = r_state;
        priority if (w_left_ev && w_right_ev) begin
            n_state = ST_HAZARD;
        end else if (r_state == ST_HAZARD) begin
            if (w_left_ev || w_right_ev) begin
                n_state = ST_IDLE;
            end
        end else if (w_left_ev) begin
            n_state = (r_state == ST_LEFT) ? ST_IDLE : ST_LEFT;
        end else if (w_right_ev) begin
            n_state = (r_state == ST_RIGHT) ? ST_IDLE : ST_RIGHT;
        end else begin
            // No event: the mode holds.
            n_state = r_state;
        end
        if (w_left_ev || w_right_ev) begin
            n_left_held  = '0;
            n_right_held = '0;
        end else begin
            n_left_held  = w_left_inc;
            n_right_held = w_right_inc;
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_left_held  <= '0;
            r_right_held <= '0;
        end else if (i_advance) begin
            r_state      <= n_state;
            r_left_held  <= n_left_held;
            r_right_held <= n_right_held;
        end
    end

    // Lamp enables and reported code for the mode after this tick.
    always_comb begin
        unique case (n_state)
            ST_IDLE: begin
                o_next_status = '{left_on: 1'b0, right_on: 1'b0, mode: MODE_IDLE};
            end
            ST_LEFT: begin
                o_next_status = '{left_on: 1'b1, right_on: 1'b0, mode: MODE_LEFT};
            end
            ST_RIGHT: begin
                o_next_status = '{left_on: 1'b0, right_on: 1'b1, mode: MODE_RIGHT};
            end
            ST_HAZARD: begin
                o_next_status = '{left_on: 1'b1, right_on: 1'b1, mode: MODE_HAZARD};
            end
            default: begin
                o_next_status = '{left_on: 1'b0, right_on: 1'b0, mode: MODE_IDLE};
            end
        endcase
    end

endmodule

@@ hw/rtl/turn_signal_hazard_controller.sv @@
// Turn-signal flasher with hazard mode: top level, blink divider and result register.
// Depends on tshc_pkg and tshc_mode_fsm.
//
// Each input beat is one 100 ms tick carrying the left and right button levels
// (active high). Holding a button for long_press_ticks toggles that side's
// indicator; both together enter hazard, and any long press in hazard returns
// to idle. A divider toggles the blink phase every blink_half_ticks ticks, and
// each result beat gives the PWM compare for both lamps (on_duty, capped at 999,
// or zero) and the mode after that tick. The counters, the mode machine and the
// divider update at the input beat and the result lands in a single output
// register, so a new tick is accepted in every cycle in which that register is
// empty or being drained. Configuration writes take effect at the next clock; the
// user must make them only while the block is idle, as the block does not enforce it.
module turn_signal_hazard_controller #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Tick channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_left_pressed,
    input  logic                              i_right_pressed,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tshc_pkg::DUTY_W-1:0]       o_left_duty,
    output logic [tshc_pkg::DUTY_W-1:0]       o_right_duty,
    output logic [tshc_pkg::MODE_W-1:0]       o_mode,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [tshc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tshc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tshc_pkg::*;

    logic [THR_W-1:0]   r_long_press;
    logic [BLINK_W-1:0] r_blink_half;
    logic [DUTY_W-1:0]  r_on_duty;

    logic [BLINK_W-1:0] r_blink_count, n_blink_count;
    logic               r_blink_phase, n_blink_phase;
    logic [BLINK_W-1:0] w_blink_inc;
    logic [BLINK_W-1:0] w_half;
    logic [DUTY_W-1:0]  w_duty;

    logic               r_out_valid;
    logic [DUTY_W-1:0]  r_left_duty, r_right_duty;
    logic [MODE_W-1:0]  r_mode;

    logic               w_accept;
    t_mode_status       w_status;

    // The output register takes a new beat when it is empty or being drained.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= RST_LONG_PRESS;
            r_blink_half <= RST_BLINK_HALF;
            r_on_duty    <= RST_ON_DUTY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS: r_long_press <= i_cfg_data[THR_W-1:0];
                CFG_BLINK_HALF: r_blink_half <= i_cfg_data[BLINK_W-1:0];
                CFG_ON_DUTY:    r_on_duty    <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tshc_mode_fsm #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_mode_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (w_accept),
        .i_left_pressed    (i_left_pressed),
        .i_right_pressed   (i_right_pressed),
        .i_long_press_ticks(r_long_press),
        .o_next_status     (w_status)
    );

    // Blink divider; a zero half period behaves as one tick.
    always_comb begin
        w_half      = (r_blink_half == '0) ? {{(BLINK_W-1){1'b0}}, 1'b1} : r_blink_half;
        w_blink_inc = r_blink_count + 1'b1;
        if (w_blink_inc >= w_half) begin
            n_blink_count = '0;
            n_blink_phase = !r_blink_phase;
        end else begin
            n_blink_count = w_blink_inc;
            n_blink_phase = r_blink_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_count <= '0;
            r_blink_phase <= 1'b0;
        end else if (w_accept) begin
            r_blink_count <= n_blink_count;
            r_blink_phase <= n_blink_phase;
        end
    end

    // Lamp compare in the on phase, capped at the timer maximum.
    assign w_duty = !n_blink_phase ? '0 : ((r_on_duty > DUTY_MAX) ? DUTY_MAX : r_on_duty);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left_duty  <= w_status.left_on  ? w_duty : '0;
            r_right_duty <= w_status.right_on ? w_duty : '0;
            r_mode       <= w_status.mode;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_left_duty  = r_left_duty;
    assign o_right_duty = r_right_duty;
    assign o_mode       = r_mode;

endmodule

@@ tb/sv/tb_turn_signal_hazard_controller.sv @@
// Self-checking testbench for turn_signal_hazard_controller: button ticks in, lamp duties out.
// Depends on tshc_pkg and the controller RTL; predicts every result beat and compares it.
`timescale 1ns / 100ps

module tb_turn_signal_hazard_controller;
    import tshc_pkg::*;

    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    // The controller has no register at this index; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [COUNT_W-1:0]   HELD_MAX   = '1;

    typedef struct packed {
        logic left;
        logic right;
    } button_tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [MODE_W-1:0] mode;
    } lamp_result_t;

    typedef enum {SEQ_LEFT, SEQ_RIGHT, SEQ_BOTH, SEQ_RELEASE, SEQ_NOISE} press_seq_t;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  i_left_pressed  = 1'b0;
    logic                  i_right_pressed = 1'b0;
    logic                  i_out_stall     = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [DUTY_W-1:0]     o_left_duty;
    logic [DUTY_W-1:0]     o_right_duty;
    logic [MODE_W-1:0]     o_mode;

    button_tick_t button_tick_q[$];
    lamp_result_t lamp_exp_q[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  stim_thr       = RST_LONG_PRESS;
    bit           idle_on        = 1'b1;

    // Shadow of the flasher: configuration and running state.
    logic [THR_W-1:0]   cfg_long_press;
    logic [BLINK_W-1:0] cfg_blink_half;
    logic [DUTY_W-1:0]  cfg_on_duty;
    logic [COUNT_W-1:0] held_left;
    logic [COUNT_W-1:0] held_right;
    logic [MODE_W-1:0]  lamp_mode;
    logic [BLINK_W-1:0] blink_cnt;
    logic               blink_on;

    turn_signal_hazard_controller #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_pressed (i_left_pressed),
        .i_right_pressed(i_right_pressed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_duty    (o_left_duty),
        .o_right_duty   (o_right_duty),
        .o_mode         (o_mode),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Advances the shadow state by one tick and returns the lamp result it produces.
    function automatic lamp_result_t advance_flasher(input logic lp, input logic rp);
        logic [THR_W-1:0]   thr;
        logic [BLINK_W-1:0] half;
        logic [DUTY_W-1:0]  duty;
        logic               lev;
        logic               rev;
        lamp_result_t       res;
        thr  = (cfg_long_press == '0) ? THR_W'(1) : cfg_long_press;
        half = (cfg_blink_half == '0) ? BLINK_W'(1) : cfg_blink_half;

        // Held counters saturate while pressed and clear on release.
        held_left  = !lp ? '0 : ((held_left == HELD_MAX) ? held_left : held_left + 1'b1);
        held_right = !rp ? '0 : ((held_right == HELD_MAX) ? held_right : held_right + 1'b1);
        lev = (held_left >= thr);
        rev = (held_right >= thr);

        // Mode machine: both events enter hazard, any event leaves it, singles toggle.
        if (lev && rev) begin
            lamp_mode = MODE_HAZARD;
        end else if (lamp_mode == MODE_HAZARD) begin
            if (lev || rev) lamp_mode = MODE_IDLE;
        end else if (lev) begin
            lamp_mode = (lamp_mode == MODE_LEFT) ? MODE_IDLE : MODE_LEFT;
        end else if (rev) begin
            lamp_mode = (lamp_mode == MODE_RIGHT) ? MODE_IDLE : MODE_RIGHT;
        end
        if (lev || rev) begin
            held_left  = '0;
            held_right = '0;
        end

        // Blink divider; a lowered period toggles on the next tick.
        blink_cnt = blink_cnt + 1'b1;
        if (blink_cnt >= half) begin
            blink_cnt = '0;
            blink_on  = ~blink_on;
        end

        duty = blink_on ? ((cfg_on_duty > DUTY_MAX) ? DUTY_MAX : cfg_on_duty) : '0;
        res.left_duty  = (lamp_mode == MODE_LEFT || lamp_mode == MODE_HAZARD) ? duty : '0;
        res.right_duty = (lamp_mode == MODE_RIGHT || lamp_mode == MODE_HAZARD) ? duty : '0;
        res.mode       = lamp_mode;
        return res;
    endfunction

    function automatic void check_lamp_field(input string name, input int unsigned want,
                                             input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Tick driver: offers queued ticks, with random idle bursts between beats.
    always @(posedge i_clk) begin : tick_driver
        int unsigned  src_gap;
        button_tick_t t;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap = 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (src_gap > 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (button_tick_q.size() > 0) begin
                t = button_tick_q.pop_front();
                i_in_valid      <= 1'b1;
                i_left_pressed  <= t.left;
                i_right_pressed <= t.right;
                if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 14);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result sink: random stall bursts, plus one long hold-off that backs up the block.
    always @(posedge i_clk) begin : result_sink
        int unsigned sink_gap;
        int unsigned hold_left;
        int unsigned results_taken;
        bit          hold_done;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_gap      = 0;
            hold_left     = 0;
            results_taken = 0;
            hold_done     = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && results_taken >= 300) begin
                hold_done = 1'b1;
                hold_left = 150;
                i_out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat, then predicts from each accepted tick beat.
    always @(posedge i_clk) begin : lamp_monitor
        lamp_result_t got;
        lamp_result_t want;
        if (!i_rst_n) begin
            cfg_long_press = RST_LONG_PRESS;
            cfg_blink_half = RST_BLINK_HALF;
            cfg_on_duty    = RST_ON_DUTY;
            held_left      = '0;
            held_right     = '0;
            lamp_mode      = MODE_IDLE;
            blink_cnt      = '0;
            blink_on       = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_left_duty, o_right_duty, o_mode};
                if (lamp_exp_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
                    mismatch_count++;
                end else begin
                    want = lamp_exp_q.pop_front();
                    check_lamp_field("left_duty", want.left_duty, got.left_duty);
                    check_lamp_field("right_duty", want.right_duty, got.right_duty);
                    check_lamp_field("mode", want.mode, got.mode);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                lamp_exp_q.push_back(advance_flasher(i_left_pressed, i_right_pressed));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LONG_PRESS: cfg_long_press = i_cfg_data[THR_W-1:0];
                    CFG_BLINK_HALF: cfg_blink_half = i_cfg_data[BLINK_W-1:0];
                    CFG_ON_DUTY:    cfg_on_duty    = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, lamp_exp_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // Writes all registers, plus a stray write to the unused index.
    task automatic set_flasher_config(input logic [CFG_DATA_W-1:0] thr,
                                      input logic [CFG_DATA_W-1:0] half,
                                      input logic [CFG_DATA_W-1:0] duty);
        write_reg(CFG_LONG_PRESS, thr);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_BLINK_HALF, half);
        write_reg(CFG_ON_DUTY, duty);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stim_thr = (thr[THR_W-1:0] == '0) ? 1 : thr[THR_W-1:0];
    endtask

    task automatic queue_ticks(input logic l, input logic r, input int unsigned n);
        repeat (n) button_tick_q.push_back('{l, r});
    endtask

    // Mostly long presses of random length around the threshold, with releases and noise.
    task automatic queue_random_ticks(input int unsigned n);
        int unsigned made;
        int unsigned len;
        press_seq_t  kind;
        made = 0;
        while (made < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: kind = SEQ_LEFT;
                3, 4, 5: kind = SEQ_RIGHT;
                6, 7:    kind = SEQ_BOTH;
                8:       kind = SEQ_RELEASE;
                default: kind = SEQ_NOISE;
            endcase
            len = stim_thr + $urandom_range(0, 3);
            len = (len > 1) ? len - 1 : 1;
            case (kind)
                SEQ_LEFT:    queue_ticks(1'b1, 1'b0, len);
                SEQ_RIGHT:   queue_ticks(1'b0, 1'b1, len);
                SEQ_BOTH:    queue_ticks(1'b1, 1'b1, len);
                SEQ_RELEASE: begin
                    len = $urandom_range(1, 4);
                    queue_ticks(1'b0, 1'b0, len);
                end
                default: begin
                    len = $urandom_range(1, 8);
                    repeat (len) button_tick_q.push_back(button_tick_t'($urandom_range(0, 3)));
                end
            endcase
            made += len;
        end
    endtask

    // Returns once every tick is sent and every result checked, then lets the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        while (button_tick_q.size() != 0 || i_in_valid || lamp_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset configuration: a left long press, then blinking at the default duty.
        queue_ticks(1'b1, 1'b0, 10);
        queue_ticks(1'b0, 1'b0, 2);
        wait_drained();

        // Short threshold, phase toggling every tick, full duty: walk every mode change.
        set_flasher_config(2, 1, 999);
        queue_ticks(1'b1, 1'b0, 2);  // left off
        queue_ticks(1'b1, 1'b0, 2);  // left on
        queue_ticks(1'b0, 1'b1, 2);  // right on
        queue_ticks(1'b1, 1'b1, 2);  // both: hazard
        queue_ticks(1'b1, 1'b0, 2);  // single press leaves hazard
        queue_ticks(1'b1, 1'b1, 2);  // hazard again
        queue_ticks(1'b0, 1'b1, 1);
        queue_ticks(1'b1, 1'b1, 1);  // right event alone leaves hazard
        queue_ticks(1'b0, 1'b0, 1);
        wait_drained();

        // Random phases; the half-period drop from 255 to 2 checks a lowered period.
        set_flasher_config(10'h305, 4, 300);
        queue_random_ticks(250);
        wait_drained();
        set_flasher_config(0, 0, 1023);
        queue_random_ticks(200);
        wait_drained();
        set_flasher_config(1, 255, 0);
        queue_random_ticks(200);
        wait_drained();
        set_flasher_config(255, 2, 999);
        queue_random_ticks(300);
        wait_drained();
        set_flasher_config(3, 7, 100);
        queue_random_ticks(200);
        wait_drained();

        // Last phase runs without idling on either side.
        idle_on = 1'b0;
        set_flasher_config(7, 1, 512);
        queue_random_ticks(200);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
